[hdl/sbrl_pkg.sv]
// Shared constants and types for the serial barcode reader link.
package sbrl_pkg;

   localparam int MAX_ENTRIES     = 16;
   localparam int DIGITS_PER_CODE = 13;
   localparam int TABLE_DEPTH     = MAX_ENTRIES * DIGITS_PER_CODE;
   localparam int ADDR_W          = $clog2(TABLE_DEPTH);
   localparam int STEP_W          = $clog2(DIGITS_PER_CODE + 2);
   localparam int ENTRY_W         = 4;
   localparam int CNT_W           = 5;

   localparam logic [1:0] FUNC_HOST = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_LOAD = 2'd2;

   localparam logic [7:0] BYTE_STX  = 8'h02;
   localparam logic [7:0] BYTE_ETX  = 8'h03;
   localparam logic [7:0] BYTE_HS_A = 8'h10;
   localparam logic [7:0] BYTE_HS_B = 8'h07;
   localparam logic [7:0] BYTE_IDLE = 8'hFF;

   localparam logic [0:0] KIND_REPLY  = 1'b0;
   localparam logic [0:0] KIND_MASTER = 1'b1;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } mem_req_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] byte_val;
      logic       master;
      logic       use_mem;
   } issue_type;

endpackage

[hdl/sbrl_table.sv]
// Barcode digit table: synchronous memory with registered read data.
module sbrl_table
   import sbrl_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [TABLE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sbrl_ctrl.sv]
// Link control: handshake tracking, frame sequencing, table access requests.
module sbrl_ctrl
   import sbrl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         func,
   input  logic [7:0]         data_byte,
   input  logic [ENTRY_W-1:0] entry_index,
   input  logic [3:0]         digit_position,
   input  logic               csr_valid,
   input  logic [CNT_W-1:0]   csr_data,
   output mem_req_type        mem_req,
   output issue_type          issue
);

   logic [STEP_W-1:0]  step_ff, step_in;
   logic               repeat_ff, repeat_in;
   logic               master_ff, master_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_use;
   logic [CNT_W-1:0]   next_entry;

   always_comb begin
      if (count_ff == '0) begin
         count_use = CNT_W'(1);
      end else if (count_ff > CNT_W'(MAX_ENTRIES)) begin
         count_use = CNT_W'(MAX_ENTRIES);
      end else begin
         count_use = count_ff;
      end
      next_entry = CNT_W'(entry_ff) + CNT_W'(1);
   end

   always_comb begin
      step_in   = step_ff;
      repeat_in = repeat_ff;
      master_in = master_ff;
      entry_in  = entry_ff;
      issue     = '0;
      mem_req   = '0;
      mem_req.rd_addr = ADDR_W'(entry_ff) * ADDR_W'(DIGITS_PER_CODE)
                      + ADDR_W'(step_ff) - ADDR_W'(1);
      mem_req.wr_addr = ADDR_W'(entry_index) * ADDR_W'(DIGITS_PER_CODE)
                      + ADDR_W'(digit_position);
      mem_req.wr_data = data_byte;
      if (accept) begin
         unique case (func)
            FUNC_HOST: begin
               issue.valid    = 1'b1;
               issue.kind     = KIND_REPLY;
               issue.byte_val = BYTE_IDLE;
               if (!master_ff) begin
                  case (step_ff)
                     STEP_W'(0): begin
                        if (data_byte == BYTE_HS_A) step_in = STEP_W'(1);
                     end
                     STEP_W'(1): begin
                        step_in = (data_byte == BYTE_HS_B) ? STEP_W'(2) : STEP_W'(0);
                     end
                     STEP_W'(2): begin
                        if (data_byte == BYTE_HS_A) begin
                           step_in        = STEP_W'(3);
                           issue.byte_val = BYTE_HS_A;
                        end else begin
                           step_in = STEP_W'(0);
                        end
                     end
                     STEP_W'(3): begin
                        step_in = STEP_W'(0);
                        if (data_byte == BYTE_HS_B) begin
                           master_in      = 1'b1;
                           issue.byte_val = BYTE_HS_B;
                        end
                     end
                     default: begin
                        step_in = STEP_W'(0);
                     end
                  endcase
               end
            end
            FUNC_TICK: begin
               if (master_ff) begin
                  issue.valid = 1'b1;
                  issue.kind  = KIND_MASTER;
                  if (step_ff == '0) begin
                     step_in        = STEP_W'(1);
                     issue.byte_val = BYTE_STX;
                  end else if (step_ff <= STEP_W'(DIGITS_PER_CODE)) begin
                     step_in       = step_ff + STEP_W'(1);
                     issue.use_mem = 1'b1;
                     mem_req.rd_en = 1'b1;
                  end else begin
                     step_in        = STEP_W'(0);
                     issue.byte_val = BYTE_ETX;
                     if (repeat_ff) begin
                        repeat_in = 1'b0;
                        master_in = 1'b0;
                        entry_in  = (next_entry >= count_use) ? '0 : next_entry[ENTRY_W-1:0];
                     end else begin
                        repeat_in = 1'b1;
                     end
                  end
               end
            end
            FUNC_LOAD: begin
               if ((CNT_W'(entry_index) < CNT_W'(MAX_ENTRIES))
                   && (digit_position < 4'(DIGITS_PER_CODE))) begin
                  mem_req.wr_en = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      issue.master = master_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         repeat_ff <= 1'b0;
         master_ff <= 1'b0;
         entry_ff  <= '0;
         count_ff  <= CNT_W'(1);
      end else begin
         step_ff   <= step_in;
         repeat_ff <= repeat_in;
         master_ff <= master_in;
         entry_ff  <= entry_in;
         if (csr_valid) count_ff <= csr_data;
      end
   end

endmodule

[hdl/serial_barcode_reader_link.sv]
// Top level of the serial barcode reader link.
//
// Input channel req_*: one transaction per host byte, byte-time tick or table
// load; it is taken when req_valid is high and req_stall is low. Result
// channel rsp_*: one transaction per host byte, and one per tick in master
// mode; ticks in slave mode, loads and unused codes give none.
// csr_*: write of barcode_count; csr_ready is always high.
// A result passes through the read stage and the output register before it
// shows on rsp_*. Throughput: one transaction per cycle while req_stall is
// low; the digit table is read at the accepting edge and its registered data
// joins the result in a second stage.
// Reset clears handshake progress, frame position, master mode and the entry
// index, and sets barcode_count to 1; the digit table holds no reset value.
// When the receiver stalls, the output register holds the result, one more
// result waits in the read stage, and req_stall rises once both are full.
module serial_barcode_reader_link
   import sbrl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_func,
   input  logic [7:0]   req_data_byte,
   input  logic [3:0]   req_entry_index,
   input  logic [3:0]   req_digit_position,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_result_kind,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_master_active,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data
);

   logic        accept;
   mem_req_type mem_req;
   issue_type   issue;
   logic [7:0]  rd_data;

   issue_type   s1_ff;
   logic        s1_adv;
   logic        out_valid_ff;
   logic        out_kind_ff;
   logic [7:0]  out_byte_ff;
   logic        out_master_ff;

   assign req_stall = s1_ff.valid && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign s1_adv    = s1_ff.valid && (!out_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   sbrl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .func           (req_func),
      .data_byte      (req_data_byte),
      .entry_index    (req_entry_index),
      .digit_position (req_digit_position),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .mem_req        (mem_req),
      .issue          (issue)
   );

   sbrl_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (issue.valid) begin
            s1_ff <= issue;
         end else if (s1_adv) begin
            s1_ff.valid <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_kind_ff   <= s1_ff.kind;
         out_byte_ff   <= s1_ff.use_mem ? rd_data : s1_ff.byte_val;
         out_master_ff <= s1_ff.master;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_master_active = out_master_ff;

endmodule
